// ===== hdl/t4t2c_pkg.sv =====
package t4t2c_pkg;

    // Default geometry and number format
    localparam int DIM_DEF       = 3;
    localparam int FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int IDX_W  = 2;
    localparam int VAL_W  = 32;
    localparam int OP_W   = 2;

    // Stream payload widths (packed fields, padded to whole bytes)
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;
    localparam int M_USED_W  = 2 * IDX_W + VAL_W;

    // Drain length after the last issued read, before the output register loads
    localparam int DP_LATENCY = 2;

    // Input item operations
    localparam logic [OP_W-1:0] OP_WR_A    = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_B    = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             issue;
        logic             first;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] x;
        logic [IDX_W-1:0] y;
        logic             load_out;
        logic             last_out;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

// ===== hdl/t4t2c_ram.sv =====
module t4t2c_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 81
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/t4t2c_ctrl.sv =====
module t4t2c_ctrl #(
    parameter int DIM = t4t2c_pkg::DIM_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [t4t2c_pkg::OP_W-1:0]      in_op,
    input  logic [t4t2c_pkg::IDX_W-1:0]     in_a,
    input  logic [t4t2c_pkg::IDX_W-1:0]     in_b,
    input  logic [t4t2c_pkg::IDX_W-1:0]     in_c,
    input  logic [t4t2c_pkg::IDX_W-1:0]     in_d,
    input  t4t2c_pkg::status_t              status,
    output t4t2c_pkg::cmd_t                 cmd
);

    localparam int IW = t4t2c_pkg::IDX_W;
    localparam logic [IW:0]   DIM_L  = (IW + 1)'(DIM);
    localparam logic [IW-1:0] IDX_MX = IW'(DIM - 1);
    localparam logic [1:0]    DRAIN_LAST = 2'(t4t2c_pkg::DP_LATENCY - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_LOAD
    } state_t;

    state_t          state_reg, state_next;
    logic [IW-1:0]   row_reg, row_next;
    logic [IW-1:0]   col_reg, col_next;
    logic [IW-1:0]   x_reg, x_next;
    logic [IW-1:0]   y_reg, y_next;
    logic [1:0]      drain_reg, drain_next;

    logic accept;
    logic ab_ok;
    logic cd_ok;
    logic term_last;
    logic elem_last;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign ab_ok     = ({1'b0, in_a} < DIM_L) && ({1'b0, in_b} < DIM_L);
    assign cd_ok     = ({1'b0, in_c} < DIM_L) && ({1'b0, in_d} < DIM_L);
    assign term_last = (x_reg == IDX_MX) && (y_reg == IDX_MX);
    assign elem_last = (row_reg == IDX_MX) && (col_reg == IDX_MX);

    // Next state, counters and commands
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        drain_next = drain_reg;

        cmd          = '0;
        cmd.row      = row_reg;
        cmd.col      = col_reg;
        cmd.x        = x_reg;
        cmd.y        = y_reg;
        cmd.last_out = elem_last;
        cmd.wr_a     = accept && (in_op == t4t2c_pkg::OP_WR_A) && ab_ok && cd_ok;
        cmd.wr_b     = accept && (in_op == t4t2c_pkg::OP_WR_B) && ab_ok;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_op == t4t2c_pkg::OP_COMPUTE))
                begin
                    row_next   = '0;
                    col_next   = '0;
                    x_next     = '0;
                    y_next     = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                cmd.issue = 1'b1;
                cmd.first = (x_reg == '0) && (y_reg == '0);
                if (y_reg == IDX_MX)
                begin
                    y_next = '0;
                    x_next = x_reg + 1'b1;
                end
                else
                begin
                    y_next = y_reg + 1'b1;
                end
                if (term_last)
                begin
                    drain_next = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == DRAIN_LAST)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    x_next       = '0;
                    y_next       = '0;
                    if (elem_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                        if (col_reg == IDX_MX)
                        begin
                            col_next = '0;
                            row_next = row_reg + 1'b1;
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            drain_reg <= drain_next;
        end
    end

endmodule

// ===== hdl/t4t2c_dp.sv =====
module t4t2c_dp #(
    parameter int DIM       = t4t2c_pkg::DIM_DEF,
    parameter int FRAC_BITS = t4t2c_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_wdata,
    input  t4t2c_pkg::cmd_t                     cmd,
    output t4t2c_pkg::status_t                  status,
    input  logic [t4t2c_pkg::IDX_W-1:0]         in_a,
    input  logic [t4t2c_pkg::IDX_W-1:0]         in_b,
    input  logic [t4t2c_pkg::IDX_W-1:0]         in_c,
    input  logic [t4t2c_pkg::IDX_W-1:0]         in_d,
    input  logic [t4t2c_pkg::VAL_W-1:0]         in_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [t4t2c_pkg::IDX_W-1:0]         out_row,
    output logic [t4t2c_pkg::IDX_W-1:0]         out_col,
    output logic [t4t2c_pkg::VAL_W-1:0]         out_value,
    output logic                                out_last
);

    localparam int VW     = t4t2c_pkg::VAL_W;
    localparam int IW     = t4t2c_pkg::IDX_W;
    localparam int A_DEP  = DIM * DIM * DIM * DIM;
    localparam int B_DEP  = DIM * DIM;
    localparam int A_AW   = $clog2(A_DEP);
    localparam int B_AW   = $clog2(B_DEP);
    localparam int PROD_W = 2 * VW;
    localparam int ACC_W  = PROD_W + $clog2(B_DEP);
    localparam logic [VW-1:0] SAT_MAX = {1'b0, {(VW - 1){1'b1}}};
    localparam logic [VW-1:0] SAT_MIN = {1'b1, {(VW - 1){1'b0}}};

    logic                     mode_reg;
    logic [A_AW-1:0]          a_waddr, a_raddr;
    logic [B_AW-1:0]          b_waddr, b_raddr;
    logic [VW-1:0]            a_rdata, b_rdata;
    logic signed [VW-1:0]     a_s, b_s;
    logic                     v1_reg, first1_reg;
    logic                     v2_reg, first2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  shifted;
    logic [ACC_W-VW:0]        hi_bits;
    logic [VW-1:0]            sat_value;
    logic                     out_valid_reg;
    logic [IW-1:0]            out_row_reg;
    logic [IW-1:0]            out_col_reg;
    logic [VW-1:0]            out_value_reg;
    logic                     out_last_reg;

    // Hold the contraction mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    // Element addresses, row-major over all indices
    assign a_waddr = A_AW'(((int'(in_a) * DIM + int'(in_b)) * DIM + int'(in_c)) * DIM
                           + int'(in_d));
    assign b_waddr = B_AW'(int'(in_a) * DIM + int'(in_b));
    assign b_raddr = B_AW'(int'(cmd.x) * DIM + int'(cmd.y));

    // Mode 1 swaps the second and third index of the A read
    always_comb
    begin
        if (mode_reg)
        begin
            a_raddr = A_AW'(((int'(cmd.row) * DIM + int'(cmd.x)) * DIM + int'(cmd.col)) * DIM
                            + int'(cmd.y));
        end
        else
        begin
            a_raddr = A_AW'(((int'(cmd.row) * DIM + int'(cmd.col)) * DIM + int'(cmd.x)) * DIM
                            + int'(cmd.y));
        end
    end

    t4t2c_ram #(
        .WIDTH (VW),
        .DEPTH (A_DEP)
    ) u_store_a (
        .clk   (clk),
        .we    (cmd.wr_a),
        .waddr (a_waddr),
        .wdata (in_value),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    t4t2c_ram #(
        .WIDTH (VW),
        .DEPTH (B_DEP)
    ) u_store_b (
        .clk   (clk),
        .we    (cmd.wr_b),
        .waddr (b_waddr),
        .wdata (in_value),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    assign a_s = $signed(a_rdata);
    assign b_s = $signed(b_rdata);

    // Track issued terms through read and multiply stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            first1_reg <= 1'b0;
            v2_reg     <= 1'b0;
            first2_reg <= 1'b0;
        end
        else
        begin
            v1_reg     <= cmd.issue;
            first1_reg <= cmd.first;
            v2_reg     <= v1_reg;
            first2_reg <= first1_reg;
        end
    end

    // Multiply the two read elements exactly
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a_s) * PROD_W'(b_s);
    end

    // Accumulate, restarting on the first term of an element
    always_comb
    begin
        if (first2_reg)
        begin
            acc_next = ACC_W'(prod_reg);
        end
        else
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    // Drop the fraction bits (floor), then saturate to the value range
    assign shifted = acc_reg >>> FRAC_BITS;
    assign hi_bits = shifted[ACC_W-1:VW-1];

    always_comb
    begin
        if ((hi_bits == '0) || (hi_bits == '1))
        begin
            sat_value = shifted[VW-1:0];
        end
        else if (shifted[ACC_W-1])
        begin
            sat_value = SAT_MIN;
        end
        else
        begin
            sat_value = SAT_MAX;
        end
    end

    // Output register: load on command, release on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_row_reg   <= cmd.row;
            out_col_reg   <= cmd.col;
            out_value_reg <= sat_value;
            out_last_reg  <= cmd.last_out;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_row         = out_row_reg;
    assign out_col         = out_col_reg;
    assign out_value       = out_value_reg;
    assign out_last        = out_last_reg;

endmodule

// ===== hdl/tensor4_tensor2_contraction_core.sv =====
// Fourth-order by second-order tensor contraction, signed fixed point.
//
// Input stream (s_*): one transfer per item. s_tuser selects the item:
// write an A element, write a B element, or compute. Writes with an index
// at or above DIM are dropped. s_tready is high only while the core is
// idle; a compute holds s_tready low until its last result is loaded
// into the output register.
// Output stream (m_*): DIM*DIM result transfers per compute, row-major,
// m_tlast on the final one. Each element accumulates DIM*DIM terms on the
// single multiply-accumulate unit, then drains the pipeline and loads the
// result into the output register before the next element starts.
// A stalled receiver holds the output register; the core finishes the
// next element and then waits until the register is free.
// Reset clears the control state and contraction_mode (to 0); the element
// stores are not cleared, and an element must be written before use.
// cfg_we writes contraction_mode from cfg_wdata; write only while idle.
module tensor4_tensor2_contraction_core #(
    parameter int DIM       = t4t2c_pkg::DIM_DEF,
    parameter int FRAC_BITS = t4t2c_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // index_a[1:0], index_b[3:2], index_c[5:4], index_d[7:6],
    // element_value[39:8]
    input  logic [t4t2c_pkg::S_TDATA_W-1:0]     s_tdata,
    // mode[1:0]
    input  logic [t4t2c_pkg::OP_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // result_row[1:0], result_col[3:2], result_value[35:4], zero[39:36]
    output logic [t4t2c_pkg::M_TDATA_W-1:0]     m_tdata,
    // last_result
    output logic                                m_tlast
);

    localparam int IW = t4t2c_pkg::IDX_W;
    localparam int VW = t4t2c_pkg::VAL_W;

    t4t2c_pkg::cmd_t    cmd;
    t4t2c_pkg::status_t status;

    logic [IW-1:0] in_a, in_b, in_c, in_d;
    logic [VW-1:0] in_value;
    logic [IW-1:0] out_row, out_col;
    logic [VW-1:0] out_value;

    // Unpack the input payload
    assign in_a     = s_tdata[IW-1:0];
    assign in_b     = s_tdata[2*IW-1:IW];
    assign in_c     = s_tdata[3*IW-1:2*IW];
    assign in_d     = s_tdata[4*IW-1:3*IW];
    assign in_value = s_tdata[4*IW+VW-1:4*IW];

    t4t2c_ctrl #(
        .DIM (DIM)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tuser),
        .in_a     (in_a),
        .in_b     (in_b),
        .in_c     (in_c),
        .in_d     (in_d),
        .status   (status),
        .cmd      (cmd)
    );

    t4t2c_dp #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .in_a      (in_a),
        .in_b      (in_b),
        .in_c      (in_c),
        .in_d      (in_d),
        .in_value  (in_value),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_value (out_value),
        .out_last  (m_tlast)
    );

    // Pack the result payload, zero padded
    assign m_tdata = {{(t4t2c_pkg::M_TDATA_W - t4t2c_pkg::M_USED_W){1'b0}},
                      out_value, out_col, out_row};

    // A compute transfer keeps the core busy in the next cycle
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == t4t2c_pkg::OP_COMPUTE) |=> !s_tready)
        else $error("core accepted an item right after a compute transfer");

    // An idle core with an empty output register produces nothing next cycle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared while the core was idle");

    // The flagged result is the last element of the matrix
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (m_tdata[IW-1:0] == IW'(DIM - 1))
                             && (m_tdata[2*IW-1:IW] == IW'(DIM - 1)))
        else $error("last result carries wrong indices");

endmodule
